// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/prb_pkg.sv -----
// ----------------------------------------------------------------------------
// prb_pkg
// Types and constants shared by the packet reorder buffer modules.
// ----------------------------------------------------------------------------
package prb_pkg;
    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [19:0] TIMEOUT_RESET = 20'd10000;
    localparam logic [39:0] BYTE_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] NONE_SEQ = 32'hFFFF_FFFF;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [2:0] ST_QUEUED = 3'd0;
    localparam logic [2:0] ST_DUP = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NOTHING = 3'd3;
    localparam logic [2:0] ST_IN_ORDER = 3'd4;
    localparam logic [2:0] ST_AFTER_GAP = 3'd5;

    typedef struct packed {
        logic [30:0] seq;
        logic [15:0] size;
        logic [15:0] tag;
        logic        rst;
        logic [1:0]  mark;
    } t_entry;

    typedef struct packed {
        logic        operation;
        logic [30:0] seq_no;
        logic [15:0] packet_size;
        logic [15:0] packet_tag;
        logic        seq_restart;
        logic [1:0]  reorder_mark;
        logic [47:0] now_us;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_tag;
        logic [30:0] out_seq;
        logic [15:0] out_size;
        logic        retransmit_valid;
        logic [15:0] retransmit_seq;
        logic [31:0] delivered_count;
        logic [31:0] skipped_count;
        logic [31:0] recovered_count;
        logic [31:0] retransmit_count;
        logic [39:0] bytes_total;
        logic [39:0] bytes_peak;
    } t_out;

    // Row command broadcast to every cell.
    typedef struct packed {
        logic   ins;     // insert new entry
        logic   pop;     // shift toward head
        logic   append;  // insert at tail regardless of order
        t_entry data;
    } t_row_cmd;
endpackage

// ----- hw/rtl/prb_if.sv -----
// ----------------------------------------------------------------------------
// prb_in_if / prb_out_if
// Valid/ready channels carrying one transaction of the buffer.
// ----------------------------------------------------------------------------
interface prb_in_if;
    logic          valid;
    logic          ready;
    prb_pkg::t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface prb_out_if;
    logic          valid;
    logic          ready;
    prb_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/packet_reorder_buffer_loss_timeout_unit.sv -----
// ----------------------------------------------------------------------------
// packet_reorder_buffer_loss_timeout_unit
// Sequence-ordered packet reorder buffer with gap timeout and retransmit.
// ----------------------------------------------------------------------------
// Channel   Dir  Carries
// s_in      in   operation, descriptor fields, current time
// m_out     out  status, delivered packet, retransmit request, counters
// cfg       in   loss timeout register write
//
// A queued enqueue compares against every cell in the work state, then shifts
// the row in the shift state before its result shows; a rejected or duplicate
// one goes straight from the work state to its result. A dequeue first pops
// any stale heads, one per pass through the work state, then shows its result.
// After the result is taken the block returns to idle, where it accepts again.
// Reset is synchronous and empties the row at once through its valid bits.
// A stalled result holds the block.
module packet_reorder_buffer_loss_timeout_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prb_in_if.sink      s_in,
    prb_out_if.source   m_out,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WORK = 4'b0010,
        S_SHFT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    prb_pkg::t_in      r_in;
    prb_pkg::t_out     r_out, n_out;
    prb_pkg::t_row_cmd w_cmd;
    logic              w_dup;
    logic              w_hv;
    prb_pkg::t_entry   w_head;

    logic [prb_pkg::CNT_W-1:0] r_fill, n_fill;
    logic [31:0] r_last, n_last;
    logic [47:0] r_fail, n_fail;
    logic        r_fv, n_fv, r_rp, n_rp, r_tp, n_tp;
    logic [31:0] r_cd, n_cd, r_cs, n_cs, r_cr, n_cr, r_ct, n_ct;
    logic [39:0] r_bt, n_bt, r_bp, n_bp;
    logic [19:0] r_to;
    logic [40:0] w_bsum;
    logic [48:0] w_dead;
    logic        w_none;
    logic [31:0] w_last1;

    prb_row u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_dup        (w_dup),
        .o_head_valid (w_hv),
        .o_head       (w_head)
    );

    assign s_in.ready  = (r_state == S_IDLE);
    assign m_out.valid = (r_state == S_OUT);
    assign m_out.payload = r_out;

    assign w_bsum  = {1'b0, r_bt} + {25'd0, r_in.packet_size};
    assign w_dead  = {1'b0, r_fail} + {29'd0, r_to};
    assign w_none  = r_last[31];
    assign w_last1 = r_last + 32'd1;

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_fill  = r_fill;
        n_last  = r_last;
        n_fail  = r_fail;
        n_fv = r_fv; n_rp = r_rp; n_tp = r_tp;
        n_cd = r_cd; n_cs = r_cs; n_cr = r_cr; n_ct = r_ct;
        n_bt = r_bt; n_bp = r_bp;
        w_cmd.ins    = 1'b0;
        w_cmd.pop    = 1'b0;
        w_cmd.append = 1'b0;
        w_cmd.data.seq  = r_in.seq_no;
        w_cmd.data.size = r_in.packet_size;
        w_cmd.data.tag  = r_in.packet_tag;
        w_cmd.data.rst  = r_in.seq_restart;
        w_cmd.data.mark = r_in.reorder_mark;
        unique case (r_state)
            S_IDLE: begin
                if (s_in.valid) begin
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                n_out = '0;
                n_out.status = prb_pkg::ST_NOTHING;
                if (r_in.operation == prb_pkg::OP_ENQ) begin
                    n_bt = w_bsum[40] ? prb_pkg::BYTE_MAX : w_bsum[39:0];
                    if (n_bt > r_bp) begin
                        n_bp = n_bt;
                    end
                    n_state = S_OUT;
                    if (r_fill == '0) begin
                        n_out.status = prb_pkg::ST_QUEUED;
                        n_state = S_SHFT;
                    end else if (r_fill == prb_pkg::CNT_W'(prb_pkg::DEPTH)) begin
                        n_out.status = prb_pkg::ST_FULL;
                    end else if (!r_in.seq_restart && w_dup) begin
                        n_out.status = prb_pkg::ST_DUP;
                    end else begin
                        n_out.status = prb_pkg::ST_QUEUED;
                        n_state = S_SHFT;
                    end
                end else if (w_hv && !w_head.rst && !w_none &&
                             {1'b0, w_head.seq} <= r_last) begin
                    // A stale head pops; the decision waits for the next head.
                    w_cmd.pop = 1'b1;
                    n_fill = r_fill - prb_pkg::CNT_W'(1);
                    n_bt = (r_bt >= {24'd0, w_head.size}) ?
                           r_bt - {24'd0, w_head.size} : '0;
                end else if (!w_hv) begin
                    if (!r_fv) begin
                        n_fail = r_in.now_us; n_fv = 1'b1; n_rp = 1'b0; n_tp = 1'b0;
                    end
                    n_state = S_OUT;
                end else if (w_head.rst || w_none || {1'b0, w_head.seq} == w_last1) begin
                    // A restart head clears the gap history and goes out at once.
                    if (!r_rp || w_head.rst) begin
                        n_cd = r_cd + 32'd1;
                    end else begin
                        n_cr = r_cr + 32'd1;
                    end
                    n_rp = 1'b0;
                    n_last = {1'b0, w_head.seq};
                    n_fv = 1'b0; n_tp = 1'b0;
                    n_out.out_tag = w_head.tag;
                    n_out.out_seq = w_head.seq;
                    n_out.out_size = w_head.size;
                    n_out.status = prb_pkg::ST_IN_ORDER;
                    w_cmd.pop = 1'b1;
                    n_fill = r_fill - prb_pkg::CNT_W'(1);
                    n_bt = (r_bt >= {24'd0, w_head.size}) ? r_bt - {24'd0, w_head.size} : '0;
                    n_state = S_OUT;
                end else if (!r_fv) begin
                    n_fail = r_in.now_us; n_fv = 1'b1;
                    n_state = S_OUT;
                end else begin
                    if (!r_tp) begin
                        n_out.retransmit_valid = 1'b1;
                        n_out.retransmit_seq = w_last1[15:0];
                        n_rp = 1'b1; n_tp = 1'b1; n_ct = r_ct + 32'd1;
                    end
                    if (w_dead <= {1'b0, r_in.now_us}) begin
                        n_cs = r_cs + 32'd1;
                        if (w_head.mark[1]) begin
                            n_last = w_last1;
                        end else if (w_head.mark == 2'd0) begin
                            n_last = {1'b0, w_head.seq};
                        end
                        n_fv = 1'b0; n_tp = 1'b0; n_rp = 1'b0;
                        n_out.out_tag = w_head.tag;
                        n_out.out_seq = w_head.seq;
                        n_out.out_size = w_head.size;
                        n_out.status = prb_pkg::ST_AFTER_GAP;
                        w_cmd.pop = 1'b1;
                        n_fill = r_fill - prb_pkg::CNT_W'(1);
                        n_bt = (r_bt >= {24'd0, w_head.size}) ?
                               r_bt - {24'd0, w_head.size} : '0;
                    end
                    n_state = S_OUT;
                end
                n_out.delivered_count  = n_cd;
                n_out.skipped_count    = n_cs;
                n_out.recovered_count  = n_cr;
                n_out.retransmit_count = n_ct;
                n_out.bytes_total      = n_bt;
                n_out.bytes_peak       = n_bp;
            end
            S_SHFT: begin
                w_cmd.ins    = 1'b1;
                w_cmd.append = r_in.seq_restart;
                n_fill = r_fill + prb_pkg::CNT_W'(1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (m_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0; r_last <= prb_pkg::NONE_SEQ; r_fail <= '0;
            r_fv <= 1'b0; r_rp <= 1'b0; r_tp <= 1'b0;
            r_cd <= '0; r_cs <= '0; r_cr <= '0; r_ct <= '0;
            r_bt <= '0; r_bp <= '0;
            r_to <= prb_pkg::TIMEOUT_RESET;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill; r_last <= n_last; r_fail <= n_fail;
            r_fv <= n_fv; r_rp <= n_rp; r_tp <= n_tp;
            r_cd <= n_cd; r_cs <= n_cs; r_cr <= n_cr; r_ct <= n_ct;
            r_bt <= n_bt; r_bp <= n_bp;
            if (i_cfg_we) begin
                r_to <= i_cfg_wdata;
            end
        end
        if (s_in.valid && s_in.ready) begin
            r_in <= s_in.payload;
        end
        r_out <= n_out;
    end
endmodule

// ----- hw/rtl/prb_cell.sv -----
// ----------------------------------------------------------------------------
// prb_cell
// One slot of the sorted entry row. It compares the new entry against its
// own, tells its left neighbor whether the tail run behind it moves, and
// takes the neighbor's data on a shift.
// ----------------------------------------------------------------------------
module prb_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prb_pkg::t_row_cmd i_cmd,
    input  logic              i_prev_valid,
    input  logic              i_prev_sfx,    // left neighbor moves right
    input  prb_pkg::t_entry   i_prev_data,   // left neighbor (toward head)
    input  logic              i_next_valid,
    input  logic              i_next_sfx,    // every slot behind this one moves
    input  prb_pkg::t_entry   i_next_data,   // right neighbor (toward tail)
    output logic              o_valid,
    output logic              o_sfx,         // this slot moves right
    output logic              o_eq,          // own seq == new seq at the stop
    output prb_pkg::t_entry   o_data
);
    logic            r_valid;
    logic            n_valid;
    prb_pkg::t_entry r_data;
    prb_pkg::t_entry n_data;
    logic            w_gt;

    // The scan runs from the tail toward the head and stops at the first
    // entry that is not greater than the new one.
    assign w_gt  = r_valid && (r_data.seq > i_cmd.data.seq);
    assign o_sfx = (!r_valid || w_gt) && i_next_sfx;
    assign o_eq  = r_valid && (r_data.seq == i_cmd.data.seq) && i_next_sfx;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_cmd.pop) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_cmd.ins) begin
            if (i_cmd.append) begin
                // Tail slot is the first empty one.
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_cmd.data;
                end
            end else if (o_sfx) begin
                // Slot moves right; it receives the new entry when the
                // neighbor stays, otherwise the neighbor's entry.
                if (i_prev_valid && i_prev_sfx) begin
                    n_data = i_prev_data;
                end else begin
                    n_data = i_cmd.data;
                end
                n_valid = r_valid || i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- hw/rtl/prb_row.sv -----
// ----------------------------------------------------------------------------
// prb_row
// The chain of cells holding the entries in ascending sequence order, apart from restart entries appended at the tail.
// ----------------------------------------------------------------------------
module prb_row (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prb_pkg::t_row_cmd i_cmd,
    output logic              o_dup,
    output logic              o_head_valid,
    output prb_pkg::t_entry   o_head
);
    logic            w_valid [prb_pkg::DEPTH];
    logic            w_sfx   [prb_pkg::DEPTH];
    logic            w_eq    [prb_pkg::DEPTH];
    prb_pkg::t_entry w_data  [prb_pkg::DEPTH];
    logic [prb_pkg::DEPTH-1:0] w_eq_vec;

    genvar g;
    generate
        for (g = 0; g < prb_pkg::DEPTH; g++) begin : g_cell
            logic            w_pv;
            logic            w_ps;
            prb_pkg::t_entry w_pd;
            logic            w_nv;
            logic            w_ns;
            prb_pkg::t_entry w_nd;
            if (g == 0) begin : g_head
                // The head behaves as if a valid, moving neighbor carrying
                // the new entry were on its left.
                assign w_pv = 1'b1;
                assign w_ps = 1'b1;
                assign w_pd = i_cmd.data;
            end else begin : g_mid
                assign w_pv = w_valid[g-1];
                assign w_ps = w_sfx[g-1];
                assign w_pd = w_data[g-1];
            end
            if (g == prb_pkg::DEPTH - 1) begin : g_tail
                assign w_nv = 1'b0;
                assign w_ns = 1'b1;
                assign w_nd = w_data[g];
            end else begin : g_body
                assign w_nv = w_valid[g+1];
                assign w_ns = w_sfx[g+1];
                assign w_nd = w_data[g+1];
            end
            prb_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (i_cmd),
                .i_prev_valid (w_pv),
                .i_prev_sfx   (w_ps),
                .i_prev_data  (w_pd),
                .i_next_valid (w_nv),
                .i_next_sfx   (w_ns),
                .i_next_data  (w_nd),
                .o_valid      (w_valid[g]),
                .o_sfx        (w_sfx[g]),
                .o_eq         (w_eq[g]),
                .o_data       (w_data[g])
            );
            assign w_eq_vec[g] = w_eq[g];
        end
    endgenerate

    assign o_dup        = |w_eq_vec;
    assign o_head_valid = w_valid[0];
    assign o_head       = w_data[0];
endmodule

// ----- hw/rtl/prb_checker.sv -----
// ----------------------------------------------------------------------------
// prb_checker
// Port-level checks of the reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input prb_pkg::t_out out_payload
);
    // One transaction in flight: no input is taken while a result waits.
    `ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready)
    // The block is busy in the cycle after it takes a transaction.
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    // The status is always one of the defined codes.
    `ASSERT_IMPL(a_status_range, i_clk, i_rst_n, out_valid,
        out_payload.status <= prb_pkg::ST_AFTER_GAP)
    // Retransmit seq is zero when no request is issued.
    `ASSERT_IMPL(a_rtx_zero, i_clk, i_rst_n, out_valid && !out_payload.retransmit_valid,
        out_payload.retransmit_seq == 16'd0)
endmodule

bind packet_reorder_buffer_loss_timeout_unit prb_checker u_prb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (s_in.valid),
    .in_ready    (s_in.ready),
    .out_valid   (m_out.valid),
    .out_ready   (m_out.ready),
    .out_payload (m_out.payload)
);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packet reorder buffer: a queue-fed driver,
// a monitor with random backpressure and a transaction-level behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we;
    logic [19:0] cfg_wdata;

    prb_in_if  in_ch ();
    prb_out_if out_ch ();

    packet_reorder_buffer_loss_timeout_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (in_ch),
        .m_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state.
    prb_pkg::t_entry held[$];
    logic [31:0] last_seq;
    logic [47:0] fail_time;
    logic        fail_armed, retry_pend, retrans_pend;
    logic [31:0] n_delivered, n_skipped, n_recovered, n_retransmit;
    logic [39:0] byte_total, byte_peak;
    logic [19:0] loss_timeout;

    prb_pkg::t_in  pending_items[$];
    prb_pkg::t_out expected_results[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   no_idle = 0;
    bit   hold = 0;
    int   send_gap = 0;
    int   stall = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic void drop_head();
        if (held.size() == 0) return;
        byte_total = (byte_total >= {24'd0, held[0].size}) ?
                     byte_total - {24'd0, held[0].size} : '0;
        void'(held.pop_front());
    endfunction

    function automatic prb_pkg::t_out reorder_step(prb_pkg::t_in x);
        prb_pkg::t_out   r;
        prb_pkg::t_entry e;
        logic [40:0] sum;
        int i;
        r = '0;
        r.status = prb_pkg::ST_NOTHING;
        if (x.operation == prb_pkg::OP_ENQ) begin
            e.seq = x.seq_no;
            e.size = x.packet_size;
            e.tag = x.packet_tag;
            e.rst = x.seq_restart;
            e.mark = x.reorder_mark;
            sum = {1'b0, byte_total} + {25'd0, x.packet_size};
            byte_total = (sum > {1'b0, prb_pkg::BYTE_MAX}) ? prb_pkg::BYTE_MAX : sum[39:0];
            if (byte_total > byte_peak) byte_peak = byte_total;
            r.status = prb_pkg::ST_QUEUED;
            if (held.size() == 0) begin
                held.insert(held.size(), e);
            end else if (held.size() >= prb_pkg::DEPTH) begin
                r.status = prb_pkg::ST_FULL;
            end else if (e.rst) begin
                held.insert(held.size(), e);
            end else begin
                i = held.size();
                while (i > 0) begin
                    if (held[i-1].seq == e.seq) begin
                        r.status = prb_pkg::ST_DUP;
                        break;
                    end
                    if (held[i-1].seq < e.seq) break;
                    i--;
                end
                if (r.status == prb_pkg::ST_QUEUED) held.insert(i, e);
            end
        end else begin
            // Stale heads go first; a restart head forgets all gap history.
            while (held.size() > 0) begin
                if (held[0].rst) begin
                    last_seq = prb_pkg::NONE_SEQ;
                    retrans_pend = 0;
                    retry_pend = 0;
                    fail_armed = 0;
                end
                if (last_seq[31] || {1'b0, held[0].seq} > last_seq) break;
                drop_head();
            end
            if (held.size() == 0) begin
                if (!fail_armed) begin
                    fail_time = x.now_us;
                    fail_armed = 1;
                    retry_pend = 0;
                    retrans_pend = 0;
                end
            end else if (last_seq[31] || {1'b0, held[0].seq} == last_seq + 32'd1) begin
                if (!retry_pend) n_delivered++;
                else begin
                    retry_pend = 0;
                    n_recovered++;
                end
                last_seq = {1'b0, held[0].seq};
                fail_armed = 0;
                retrans_pend = 0;
                r.out_tag = held[0].tag;
                r.out_seq = held[0].seq;
                r.out_size = held[0].size;
                drop_head();
                r.status = prb_pkg::ST_IN_ORDER;
            end else if (!fail_armed) begin
                fail_time = x.now_us;
                fail_armed = 1;
            end else begin
                if (!retrans_pend) begin
                    r.retransmit_valid = 1;
                    r.retransmit_seq = 16'(last_seq + 32'd1);
                    retry_pend = 1;
                    retrans_pend = 1;
                    n_retransmit++;
                end
                if (64'(fail_time) + 64'(loss_timeout) <= 64'(x.now_us)) begin
                    n_skipped++;
                    // Mark true steps past the hole; no mark jumps to the head.
                    if (held[0].mark[1]) last_seq = last_seq + 32'd1;
                    else if (held[0].mark == 2'd0) last_seq = {1'b0, held[0].seq};
                    fail_armed = 0;
                    retrans_pend = 0;
                    retry_pend = 0;
                    r.out_tag = held[0].tag;
                    r.out_seq = held[0].seq;
                    r.out_size = held[0].size;
                    drop_head();
                    r.status = prb_pkg::ST_AFTER_GAP;
                end
            end
        end
        r.delivered_count = n_delivered;
        r.skipped_count = n_skipped;
        r.recovered_count = n_recovered;
        r.retransmit_count = n_retransmit;
        r.bytes_total = byte_total;
        r.bytes_peak = byte_peak;
        return r;
    endfunction

    // Driver: one transaction offered at a time, random gaps (possibly none) between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.insert(expected_results.size(),
                                        reorder_step(in_ch.payload));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (!hold && pending_items.size() > 0) begin
                    in_ch.payload <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            errors++;
        end
    endfunction

    // Monitor: random backpressure and field-by-field compare.
    always @(posedge i_clk) begin
        prb_pkg::t_out e, a;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                a = out_ch.payload;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, a.status);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", 64'(e.status), 64'(a.status));
                    check_field("out_tag", 64'(e.out_tag), 64'(a.out_tag));
                    check_field("out_seq", 64'(e.out_seq), 64'(a.out_seq));
                    check_field("out_size", 64'(e.out_size), 64'(a.out_size));
                    check_field("retransmit_valid", 64'(e.retransmit_valid),
                                64'(a.retransmit_valid));
                    check_field("retransmit_seq", 64'(e.retransmit_seq),
                                64'(a.retransmit_seq));
                    check_field("delivered_count", 64'(e.delivered_count),
                                64'(a.delivered_count));
                    check_field("skipped_count", 64'(e.skipped_count),
                                64'(a.skipped_count));
                    check_field("recovered_count", 64'(e.recovered_count),
                                64'(a.recovered_count));
                    check_field("retransmit_count", 64'(e.retransmit_count),
                                64'(a.retransmit_count));
                    check_field("bytes_total", 64'(e.bytes_total), 64'(a.bytes_total));
                    check_field("bytes_peak", 64'(e.bytes_peak), 64'(a.bytes_peak));
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall <= pick_gap();
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    logic [30:0] next_seq;
    logic [47:0] clock_us;

    task automatic add_item(logic op, logic [30:0] seq, logic [15:0] size, logic [15:0] tag,
                            logic rs, logic [1:0] mark, logic [47:0] now);
        prb_pkg::t_in x;
        x.operation = op;
        x.seq_no = seq;
        x.packet_size = size;
        x.packet_tag = tag;
        x.seq_restart = rs;
        x.reorder_mark = mark;
        x.now_us = now;
        pending_items.insert(pending_items.size(), x);
    endtask

    task automatic add_enq(logic [30:0] seq, logic rs);
        add_item(prb_pkg::OP_ENQ, seq, 16'($urandom), 16'($urandom), rs,
                 2'($urandom_range(0, 3)), clock_us);
    endtask

    task automatic add_deq();
        add_item(prb_pkg::OP_DEQ, 31'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                 2'($urandom), clock_us);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !in_ch.valid && expected_results.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [19:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        loss_timeout = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int r, k, j;
        k = 0;
        while (k < n) begin
            r = $urandom_range(0, 99);
            clock_us += 48'($urandom_range(0, 400));
            if ($urandom_range(0, 99) < 2) clock_us = 48'({$urandom, $urandom});
            else if ($urandom_range(0, 99) < 2) clock_us -= 48'($urandom_range(0, 2000));
            if (r < 45) begin
                add_deq();
            end else if (r < 85) begin
                j = $urandom_range(0, 9);
                if (j < 6) begin
                    add_enq(next_seq, 1'b0);
                    next_seq++;
                end else if (j < 8) begin
                    add_enq(next_seq + 31'd1, 1'b0);
                    next_seq += 31'd2;
                end else if (j == 8) begin
                    add_enq(next_seq - 31'($urandom_range(1, 4)), 1'b0);
                end else begin
                    add_enq(next_seq + 31'($urandom_range(2, 5)), 1'b0);
                end
            end else if (r < 88) begin
                next_seq = 31'($urandom);
                add_enq(next_seq, 1'b1);
                next_seq++;
            end else if (r < 89) begin
                // Overfill so the full-buffer rejection is reached.
                repeat (66) begin
                    add_enq(next_seq, 1'b0);
                    next_seq++;
                end
                k += 65;
            end else begin
                add_item(1'($urandom), 31'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom), 2'($urandom), 48'({$urandom, $urandom}));
            end
            k++;
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        held.delete();
        last_seq = prb_pkg::NONE_SEQ;
        fail_time = '0;
        fail_armed = 0;
        retry_pend = 0;
        retrans_pend = 0;
        n_delivered = '0;
        n_skipped = '0;
        n_recovered = '0;
        n_retransmit = '0;
        byte_total = '0;
        byte_peak = '0;
        loss_timeout = prb_pkg::TIMEOUT_RESET;
        next_seq = 31'd100;
        clock_us = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty dequeue, duplicates, gap with retransmit and
        // timeout skip, sequence wrap, restart at head, field extremes.
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd0);
        add_item(prb_pkg::OP_ENQ, 31'd5, 16'hFFFF, 16'hFFFF, 1'b0, 2'd0, 48'd10);
        add_item(prb_pkg::OP_ENQ, 31'd5, 16'd1, 16'd1, 1'b0, 2'd0, 48'd11);
        add_item(prb_pkg::OP_ENQ, 31'd3, 16'd0, 16'd0, 1'b0, 2'd1, 48'd12);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd20);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd30);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd40);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd10030);
        add_item(prb_pkg::OP_ENQ, 31'd9, 16'd7, 16'h1234, 1'b0, 2'd1, 48'd10031);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd10032);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd10033);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd30000);
        add_item(prb_pkg::OP_ENQ, 31'h7FFF_FFFE, 16'd2, 16'h5555, 1'b0, 2'd3, 48'd30001);
        add_item(prb_pkg::OP_ENQ, 31'h7FFF_FFFF, 16'd3, 16'hAAAA, 1'b0, 2'd2, 48'd30002);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd30003);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd30004);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'd30005);
        add_item(prb_pkg::OP_ENQ, 31'd0, 16'd4, 16'h0F0F, 1'b1, 2'd0, 48'd30006);
        add_item(prb_pkg::OP_ENQ, 31'd2, 16'd4, 16'h0F0F, 1'b1, 2'd0, 48'd30007);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'hFFFF_FFFF_FFFF);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'hFFFF_FFFF_FFFF);
        add_item(prb_pkg::OP_DEQ, '0, '0, '0, 1'b0, 2'd0, 48'hFFFF_FFFF_FFFF);
        clock_us = 48'd40000;
        drain();

        set_timeout(20'd0);
        random_phase(360);
        // Let the sender sit until every result is back before resuming.
        hold = 1;
        wait (expected_results.size() == 0 && !in_ch.valid);
        hold = 0;
        drain();

        set_timeout(20'hFFFFF);
        no_idle = 1;
        random_phase(360);
        drain();
        no_idle = 0;

        set_timeout(20'd3000);
        random_phase(360);
        drain();

        set_timeout(20'd500);
        random_phase(360);
        drain();

        set_timeout(20'd1000000);
        random_phase(360);
        drain();
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
